// ----- src/dq_pkg.sv -----
// shared constants, codes and types for the double-ended queue
// no dependencies
`default_nettype none

package dq_pkg;

  localparam int DEPTH = 256;
  localparam int WIDTH = 32;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = AW + 1;
  localparam int IXW = (CW > 8) ? CW : 8;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ       = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AW-1:0]    addr;
    logic [WIDTH-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic               valid;
    logic               rd;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

// ----- src/dq_ram.sv -----
// single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module dq_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic                          re,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] addr,
  input  wire logic [W-1:0]                  wdata,
  output logic      [W-1:0]                  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/dq_ctrl.sv -----
// request decode, front pointer and count of the ring buffer
// depends on dq_pkg
`default_nettype none

module dq_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [dq_pkg::FUNC_W-1:0]    func,
  input  wire logic [dq_pkg::VALUE_W-1:0]   value,
  input  wire logic [dq_pkg::INDEX_W-1:0]   index,
  output dq_pkg::ram_req_t                  req,
  output dq_pkg::result_t                   res
);

  localparam int AW  = dq_pkg::AW;
  localparam int CW  = dq_pkg::CW;
  localparam int IXW = dq_pkg::IXW;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                  full, empty;
  logic [AW-1:0]         front_dec, front_inc;
  logic [IXW-1:0]        idx_w, cnt_w;
  dq_pkg::status_t       status;
  logic                  rd;

  // slot of the entry at offset off from the front
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] fp, input logic [CW-1:0] off);
    logic [CW-1:0] sum;
    sum = {1'b0, fp} + off;
    if (sum >= CW'(dq_pkg::DEPTH)) begin
      sum = sum - CW'(dq_pkg::DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count_r == CW'(dq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? AW'(dq_pkg::DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == AW'(dq_pkg::DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign idx_w     = IXW'(index);
  assign cnt_w     = IXW'(count_r);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    status    = dq_pkg::ST_OK;
    rd        = 1'b0;
    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = front_r;
    req.wdata = dq_pkg::WIDTH'(value);
    unique case (func)
      dq_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
          req.we    = accept;
          req.addr  = front_dec;
        end
      end
      dq_pkg::FN_PUSH_BACK: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          req.we    = accept;
          req.addr  = slot_at(front_r, count_r);
        end
      end
      dq_pkg::FN_POP_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
          rd        = 1'b1;
          req.re    = accept;
          req.addr  = front_r;
        end
      end
      dq_pkg::FN_POP_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          rd        = 1'b1;
          req.re    = accept;
          req.addr  = slot_at(front_r, count_r - 1'b1);
        end
      end
      dq_pkg::FN_READ: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else if (idx_w >= cnt_w) begin
          status = dq_pkg::ST_RANGE;
        end else begin
          rd       = 1'b1;
          req.re   = accept;
          req.addr = slot_at(front_r, CW'(index));
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid  = accept;
  assign res.rd     = rd;
  assign res.status = status;
  assign res.count  = dq_pkg::COUNT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/double_ended_queue.sv -----
// top level of the double-ended queue: request control, entry ram, result register
// depends on dq_pkg, dq_ram, dq_ctrl
//
//  channel  handshake          payload
//  request  start / busy       in_func, in_value, in_index
//  result   out_strobe         out_data, out_status, out_count
//
// one request per cycle while busy is low; its result shows in the cycle after
// acceptance, from the entry ram's registered read port
// synchronous active-low reset clears pointer, count and strobe; busy is high
// during reset and for the cycle after it
// results cannot be held off: each stands for exactly one cycle
`default_nettype none

module double_ended_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dq_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [dq_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [dq_pkg::INDEX_W-1:0]    in_index,
  output logic                               out_strobe,
  output logic      [dq_pkg::DATA_W-1:0]     out_data,
  output logic      [dq_pkg::STATUS_W-1:0]   out_status,
  output logic      [dq_pkg::COUNT_W-1:0]    out_count
);

  logic                     busy_r;
  logic                     accept;
  dq_pkg::ram_req_t         req;
  dq_pkg::result_t          res;
  logic                     strobe_r;
  logic                     rd_r;
  dq_pkg::status_t          status_r;
  logic [dq_pkg::COUNT_W-1:0] count_r;
  logic [dq_pkg::WIDTH-1:0] rdata;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  dq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_func),
    .value  (in_value),
    .index  (in_index),
    .req    (req),
    .res    (res)
  );

  dq_ram #(
    .W (dq_pkg::WIDTH),
    .D (dq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      rd_r     <= res.rd;
      status_r <= res.status;
      count_r  <= res.count;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = rd_r ? dq_pkg::DATA_W'(rdata) : '0;
  assign out_status = status_r;
  assign out_count  = count_r;

endmodule

`default_nettype wire

// ----- verif/dq_checker.sv -----
// result checker for the double-ended queue: keeps a shadow ring of the entries,
// predicts each result beat from the accepted request beats and compares field by field
// depends on dq_pkg
`timescale 1ns / 100ps

module dq_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [dq_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [dq_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [dq_pkg::INDEX_W-1:0]    in_index,
  input  wire logic                          out_strobe,
  input  wire logic [dq_pkg::DATA_W-1:0]     out_data,
  input  wire logic [dq_pkg::STATUS_W-1:0]   out_status,
  input  wire logic [dq_pkg::COUNT_W-1:0]    out_count,
  output int                                 fail_count,
  output int                                 beats_due
);
  import dq_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } reply_t;

  reply_t           replies_due[$];
  logic [WIDTH-1:0] shadow_slots [DEPTH];
  int               shadow_front;
  int               shadow_held;
  int               errs = 0;

  function automatic int slot_from_front(input int offset);
    return (shadow_front + offset) % DEPTH;
  endfunction

  task automatic apply_request(input logic [FUNC_W-1:0] func,
                               input logic [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index,
                               output reply_t reply);
    reply.data   = '0;
    reply.status = ST_OK;
    case (func)
      FN_PUSH_FRONT: begin
        if (shadow_held >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
          shadow_slots[shadow_front] = value[WIDTH-1:0];
          shadow_held++;
        end
      end
      FN_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          shadow_slots[slot_from_front(shadow_held)] = value[WIDTH-1:0];
          shadow_held++;
        end
      end
      FN_POP_FRONT: begin
        if (shadow_held == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.data   = shadow_slots[shadow_front];
          shadow_front = slot_from_front(1);
          shadow_held--;
        end
      end
      FN_POP_BACK: begin
        if (shadow_held == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.data = shadow_slots[slot_from_front(shadow_held - 1)];
          shadow_held--;
        end
      end
      FN_READ: begin
        if (shadow_held == 0) begin
          reply.status = ST_EMPTY;
        end else if (int'(index) >= shadow_held) begin
          reply.status = ST_RANGE;
        end else begin
          reply.data = shadow_slots[slot_from_front(int'(index))];
        end
      end
      default: begin
      end
    endcase
    reply.count = COUNT_W'(shadow_held);
  endtask

  always @(posedge clk) begin : watch_beats
    reply_t due;
    reply_t predicted;
    if (!rst_n) begin
      shadow_front = 0;
      shadow_held  = 0;
      replies_due.delete();
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no request outstanding");
          errs++;
        end else begin
          due = replies_due.pop_front();
          if (out_data !== due.data) begin
            $error("out_data mismatch: expected %h, actual %h", due.data, out_data);
            errs++;
          end
          if (out_status !== due.status) begin
            $error("out_status mismatch: expected %0d, actual %0d", due.status, out_status);
            errs++;
          end
          if (out_count !== due.count) begin
            $error("out_count mismatch: expected %0d, actual %0d", due.count, out_count);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        apply_request(in_func, in_value, in_index, predicted);
        replies_due.push_back(predicted);
      end
    end
    fail_count <= errs;
    beats_due  <= replies_due.size();
  end

endmodule

// ----- verif/tb_double_ended_queue.sv -----
// testbench top for the double-ended queue: clock, reset, request stimulus and verdict
// depends on dq_pkg, double_ended_queue and dq_checker
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;
  localparam int RANDOM_BEATS = 1600;
  localparam int CALM_TAIL    = 200;
  localparam int STALL_LIMIT  = 400;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  in_func;
  logic [VALUE_W-1:0] in_value;
  logic [INDEX_W-1:0] in_index;
  logic               out_strobe;
  logic [DATA_W-1:0]  out_data;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_count;
  int                 fail_count;
  int                 beats_due;
  int                 quiet_cycles;

  double_ended_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_value   (in_value),
    .in_index   (in_index),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

  dq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_value   (in_value),
    .in_index   (in_index),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("double_ended_queue test failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [VALUE_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
    start    <= 1'b1;
    in_func  <= func;
    in_value <= value;
    in_index <= index;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(15, 1)) @(posedge clk);
  endtask

  function automatic logic [FUNC_W-1:0] pick_func(input mix_t mix);
    int roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 40) return FN_PUSH_FRONT;
        if (roll < 80) return FN_PUSH_BACK;
        if (roll < 88) return FN_READ;
        if (roll < 94) return FN_POP_FRONT;
        if (roll < 98) return FN_POP_BACK;
      end
      MIX_DRAIN: begin
        if (roll < 8)  return FN_PUSH_FRONT;
        if (roll < 16) return FN_PUSH_BACK;
        if (roll < 26) return FN_READ;
        if (roll < 60) return FN_POP_FRONT;
        if (roll < 96) return FN_POP_BACK;
      end
      default: begin
        if (roll < 20) return FN_PUSH_FRONT;
        if (roll < 40) return FN_PUSH_BACK;
        if (roll < 60) return FN_READ;
        if (roll < 78) return FN_POP_FRONT;
        if (roll < 96) return FN_POP_BACK;
      end
    endcase
    return FUNC_W'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
  endfunction

  initial begin : stimulus
    int   n;
    bit   idle_on;
    mix_t mix;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_func  = FN_PUSH_FRONT;
    in_value = '0;
    in_index = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, spare codes, extremes of the fields
    send_request(FN_POP_FRONT, 32'hFFFF_FFFF, 8'd0);
    send_request(FN_POP_BACK, '0, 8'd0);
    send_request(FN_READ, '0, 8'd0);
    send_request(FN_READ, '0, 8'd255);
    send_request(FN_SPARE_FIRST, 32'hFFFF_FFFF, 8'd255);
    send_request(FN_SPARE_LAST, '0, 8'd0);
    idle_burst();
    send_request(FUNC_W'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST)), $urandom, 8'd1);
    send_request(FN_PUSH_BACK, 32'hFFFF_FFFF, 8'd0);
    send_request(FN_PUSH_FRONT, '0, 8'd255);
    send_request(FN_PUSH_BACK, 32'hA5A5_5A5A, 8'd0);
    send_request(FN_READ, '0, 8'd0);
    send_request(FN_READ, '0, 8'd1);
    send_request(FN_READ, '0, 8'd2);
    idle_burst();
    send_request(FN_READ, '0, 8'd3);
    send_request(FN_READ, '0, 8'd255);
    send_request(FN_POP_FRONT, '0, 8'd0);
    send_request(FN_POP_BACK, '0, 8'd0);
    send_request(FN_PUSH_FRONT, 32'h5A5A_A5A5, 8'd0);
    send_request(FN_POP_BACK, '0, 8'd0);
    send_request(FN_POP_FRONT, '0, 8'd0);
    send_request(FN_POP_FRONT, '0, 8'd0);
    send_request(FN_READ, '0, 8'd0);

    idle_on = 1'b1;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n < 350)       mix = MIX_FILL;
      else if (n < 700)  mix = MIX_DRAIN;
      else if (n < 1050) mix = MIX_FILL;
      else if (n < 1400) mix = MIX_DRAIN;
      else               mix = MIX_EVEN;
      if (n % 64 == 0) idle_on = $urandom_range(1);
      send_request(pick_func(mix), $urandom,
                   ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(15))
                                            : INDEX_W'($urandom_range(255)));
      if (n < RANDOM_BEATS - CALM_TAIL && idle_on && $urandom_range(7) == 0) idle_burst();
    end
    start <= 1'b0;

    while (beats_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule
